// ===== rtl/core/bcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcsp_pkg
// Shared types and constants of the binary command stream parser.
// ----------------------------------------------------------------------------
package bcsp_pkg;

    // Parse phases of the front end, one-hot.
    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_COUNT     = 12'b0000_0000_0010,
        PH_OPCODE    = 12'b0000_0000_0100,
        PH_FLAGS     = 12'b0000_0000_1000,
        PH_NC_ID     = 12'b0000_0001_0000,
        PH_NC_TYPE   = 12'b0000_0010_0000,
        PH_NC_PARENT = 12'b0000_0100_0000,
        PH_TS_NODE   = 12'b0000_1000_0000,
        PH_TS_LEN    = 12'b0001_0000_0000,
        PH_TS_SKIP   = 12'b0010_0000_0000,
        PH_LS_NODE   = 12'b0100_0000_0000,
        PH_LS_DATA   = 12'b1000_0000_0000
    } phase_t;

    localparam logic [7:0] OP_BATCH  = 8'h00;
    localparam logic [7:0] OP_NODE   = 8'h10;
    localparam logic [7:0] OP_TEXT   = 8'h30;
    localparam logic [7:0] OP_LAYOUT = 8'h41;

    // Shift position past which varuint payload bits are dropped.
    localparam logic [5:0] VU_SHIFT_LIMIT = 6'd32;
    localparam logic [5:0] VU_SHIFT_STEP  = 6'd7;

    typedef enum logic [2:0] {
        KIND_BATCH   = 3'd0,
        KIND_NODE    = 3'd1,
        KIND_TEXT    = 3'd2,
        KIND_LAYOUT  = 3'd3,
        KIND_UNKNOWN = 3'd4
    } kind_t;

    // Raw command record as the front end finds it; fields that do not
    // belong to the kind are masked by the back end.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] number;
        logic [31:0] node;
        logic [7:0]  misc;
        logic [31:0] plen;
        logic [63:0] layout;
    } cmd_rec_t;

    typedef struct packed {
        logic     valid;
        cmd_rec_t rec;
    } cmd_slot_t;

endpackage

// ===== rtl/core/bcsp_if.sv =====
// ----------------------------------------------------------------------------
// bcsp_if
// Valid/ready channels of the parser: frame words in, command words out.
// ----------------------------------------------------------------------------
interface bcsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       frame_first;
    logic       frame_last;

    modport source (output valid, output in_byte, output frame_first,
                    output frame_last, input ready);
    modport sink (input valid, input in_byte, input frame_first,
                  input frame_last, output ready);
endinterface

interface bcsp_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         cmd_kind;
    logic [31:0]        cmd_number;
    logic [31:0]        node_ident;
    logic [7:0]         small_field;
    logic [31:0]        parent_or_length;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        size_w;
    logic [15:0]        size_h;

    modport source (output valid, output cmd_kind, output cmd_number,
                    output node_ident, output small_field,
                    output parent_or_length, output pos_x, output pos_y,
                    output size_w, output size_h, input ready);
    modport sink (input valid, input cmd_kind, input cmd_number,
                  input node_ident, input small_field,
                  input parent_or_length, input pos_x, input pos_y,
                  input size_w, input size_h, output ready);
endinterface

// ===== rtl/core/bcsp_front.sv =====
// ----------------------------------------------------------------------------
// bcsp_front
// Byte-level frame parser: tracks the parse phase, decodes varuints and
// pushes one raw command record per completed command.
// ----------------------------------------------------------------------------
module bcsp_front
    import bcsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bcsp_byte_if.sink     frame,
    input  logic          queue_full,
    output cmd_slot_t     push
);

    phase_t      phase_reg,  phase_next;
    logic [2:0]  bcount_reg, bcount_next;
    logic [31:0] left_reg,   left_next;
    logic [31:0] index_reg,  index_next;
    logic [31:0] acc_reg,    acc_next;
    logic [5:0]  shift_reg,  shift_next;
    logic [31:0] node_reg,   node_next;
    logic [7:0]  type_reg,   type_next;
    logic [31:0] len_reg,    len_next;
    logic [31:0] skip_reg,   skip_next;
    logic [63:0] layout_reg, layout_next;

    logic        fire;
    logic [7:0]  b;
    phase_t      cur_phase;
    logic [2:0]  cur_bcount;
    logic [31:0] cur_left;
    logic [31:0] cur_index;
    logic [31:0] cur_acc;
    logic [5:0]  cur_shift;
    logic [31:0] vu_wide;
    logic [31:0] vu_acc;
    logic [5:0]  vu_shift;
    logic        vu_done;
    logic        do_advance;

    assign frame.ready = !queue_full;
    assign fire        = frame.valid && frame.ready;
    assign b           = frame.in_byte;

    // A first word restarts the parser at the count phase with its counters cleared.
    always_comb
    begin
        cur_phase  = frame.frame_first ? PH_COUNT : phase_reg;
        cur_bcount = frame.frame_first ? 3'd0 : bcount_reg;
        cur_left   = frame.frame_first ? 32'd0 : left_reg;
        cur_index  = frame.frame_first ? 32'd0 : index_reg;
        cur_acc    = frame.frame_first ? 32'd0 : acc_reg;
        cur_shift  = frame.frame_first ? 6'd0 : shift_reg;
    end

    // One LEB128 step; payload bits that land at bit 32 or above are lost.
    always_comb
    begin
        vu_wide  = {25'd0, b[6:0]} << cur_shift;
        vu_acc   = (cur_shift < VU_SHIFT_LIMIT) ? (cur_acc | vu_wide) : cur_acc;
        vu_shift = (cur_shift < VU_SHIFT_LIMIT) ? (cur_shift + VU_SHIFT_STEP) : cur_shift;
        vu_done  = !b[7];
    end

    always_comb
    begin
        phase_next  = phase_reg;
        bcount_next = bcount_reg;
        left_next   = left_reg;
        index_next  = index_reg;
        acc_next    = acc_reg;
        shift_next  = shift_reg;
        node_next   = node_reg;
        type_next   = type_reg;
        len_next    = len_reg;
        skip_next   = skip_reg;
        layout_next = layout_reg;
        do_advance  = 1'b0;

        push.valid       = 1'b0;
        push.rec.kind    = KIND_UNKNOWN;
        push.rec.number  = cur_index;
        push.rec.node    = node_reg;
        push.rec.misc    = b;
        push.rec.plen    = len_reg;
        push.rec.layout  = {layout_reg[55:0], b};

        if (fire)
        begin
            phase_next  = cur_phase;
            bcount_next = cur_bcount;
            left_next   = cur_left;
            index_next  = cur_index;
            acc_next    = cur_acc;
            shift_next  = cur_shift;

            unique case (cur_phase)
                PH_IDLE:
                begin
                end
                PH_COUNT:
                begin
                    left_next = {cur_left[23:0], b};
                    if (cur_bcount == 3'd3)
                    begin
                        bcount_next = 3'd0;
                        index_next  = 32'd0;
                        phase_next  = ({cur_left[23:0], b} == 32'd0) ? PH_IDLE : PH_OPCODE;
                    end
                    else
                    begin
                        bcount_next = cur_bcount + 3'd1;
                    end
                end
                PH_OPCODE:
                begin
                    acc_next   = 32'd0;
                    shift_next = 6'd0;
                    priority if (b == OP_BATCH)
                        phase_next = PH_FLAGS;
                    else if (b == OP_NODE)
                        phase_next = PH_NC_ID;
                    else if (b == OP_TEXT)
                        phase_next = PH_TS_NODE;
                    else if (b == OP_LAYOUT)
                        phase_next = PH_LS_NODE;
                    else
                    begin
                        push.valid    = 1'b1;
                        push.rec.kind = KIND_UNKNOWN;
                        phase_next    = PH_IDLE;
                    end
                end
                PH_FLAGS:
                begin
                    push.valid    = 1'b1;
                    push.rec.kind = KIND_BATCH;
                    do_advance    = 1'b1;
                end
                PH_NC_ID, PH_TS_NODE:
                begin
                    acc_next   = vu_acc;
                    shift_next = vu_shift;
                    if (vu_done)
                    begin
                        node_next  = vu_acc;
                        acc_next   = 32'd0;
                        shift_next = 6'd0;
                        phase_next = (cur_phase == PH_NC_ID) ? PH_NC_TYPE : PH_TS_LEN;
                    end
                end
                PH_NC_TYPE:
                begin
                    type_next  = b;
                    phase_next = PH_NC_PARENT;
                end
                PH_NC_PARENT:
                begin
                    acc_next   = vu_acc;
                    shift_next = vu_shift;
                    if (vu_done)
                    begin
                        push.valid     = 1'b1;
                        push.rec.kind  = KIND_NODE;
                        push.rec.misc  = type_reg;
                        push.rec.plen  = vu_acc;
                        do_advance     = 1'b1;
                    end
                end
                PH_TS_LEN:
                begin
                    acc_next   = vu_acc;
                    shift_next = vu_shift;
                    if (vu_done)
                    begin
                        len_next  = vu_acc;
                        skip_next = vu_acc;
                        if (vu_acc == 32'd0)
                        begin
                            push.valid    = 1'b1;
                            push.rec.kind = KIND_TEXT;
                            push.rec.plen = 32'd0;
                            do_advance    = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_TS_SKIP;
                        end
                    end
                end
                PH_TS_SKIP:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1)
                    begin
                        push.valid    = 1'b1;
                        push.rec.kind = KIND_TEXT;
                        do_advance    = 1'b1;
                    end
                end
                PH_LS_NODE:
                begin
                    acc_next   = vu_acc;
                    shift_next = vu_shift;
                    if (vu_done)
                    begin
                        node_next   = vu_acc;
                        bcount_next = 3'd0;
                        phase_next  = PH_LS_DATA;
                    end
                end
                PH_LS_DATA:
                begin
                    layout_next = {layout_reg[55:0], b};
                    if (cur_bcount == 3'd7)
                    begin
                        bcount_next   = 3'd0;
                        push.valid    = 1'b1;
                        push.rec.kind = KIND_LAYOUT;
                        do_advance    = 1'b1;
                    end
                    else
                    begin
                        bcount_next = cur_bcount + 3'd1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase

            if (do_advance)
            begin
                index_next = cur_index + 32'd1;
                left_next  = cur_left - 32'd1;
                phase_next = (cur_left == 32'd1) ? PH_IDLE : PH_OPCODE;
            end

            if (frame.frame_last)
            begin
                phase_next  = PH_IDLE;
                bcount_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            bcount_reg <= 3'd0;
            left_reg   <= 32'd0;
            index_reg  <= 32'd0;
            acc_reg    <= 32'd0;
            shift_reg  <= 6'd0;
            skip_reg   <= 32'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            bcount_reg <= bcount_next;
            left_reg   <= left_next;
            index_reg  <= index_next;
            acc_reg    <= acc_next;
            shift_reg  <= shift_next;
            skip_reg   <= skip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        type_reg   <= type_next;
        len_reg    <= len_next;
        layout_reg <= layout_next;
    end

endmodule

// ===== rtl/core/bcsp_queue.sv =====
// ----------------------------------------------------------------------------
// bcsp_queue
// Small FIFO of command records between the parser and the output stage.
// ----------------------------------------------------------------------------
module bcsp_queue
    import bcsp_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_slot_t push,
    input  logic      pop,
    output cmd_slot_t head,
    output logic      full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_rec_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.rec   = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && !full;
    assign do_pop  = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push.rec;
    end

endmodule

// ===== rtl/core/bcsp_back.sv =====
// ----------------------------------------------------------------------------
// bcsp_back
// Output stage: takes records from the queue, clears the fields that do not
// belong to the command kind and holds the word until it is taken.
// ----------------------------------------------------------------------------
module bcsp_back
    import bcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_slot_t   head,
    output logic        pop,
    bcsp_cmd_if.source  command
);

    logic        valid_reg, valid_next;
    kind_t       kind_reg;
    logic [31:0] number_reg;
    logic [31:0] node_reg;
    logic [7:0]  small_reg;
    logic [31:0] plen_reg;
    logic [63:0] layout_reg;

    logic        load;
    kind_t       k;
    logic [31:0] node_fmt;
    logic [7:0]  small_fmt;
    logic [31:0] plen_fmt;
    logic [63:0] layout_fmt;

    assign load = head.valid && (!valid_reg || command.ready);
    assign pop  = load;
    assign k    = head.rec.kind;

    always_comb
    begin
        node_fmt   = (k == KIND_NODE || k == KIND_TEXT || k == KIND_LAYOUT)
                     ? head.rec.node : 32'd0;
        small_fmt  = (k == KIND_BATCH || k == KIND_NODE || k == KIND_UNKNOWN)
                     ? head.rec.misc : 8'd0;
        plen_fmt   = (k == KIND_NODE || k == KIND_TEXT) ? head.rec.plen : 32'd0;
        layout_fmt = (k == KIND_LAYOUT) ? head.rec.layout : 64'd0;
    end

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (command.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= k;
            number_reg <= head.rec.number;
            node_reg   <= node_fmt;
            small_reg  <= small_fmt;
            plen_reg   <= plen_fmt;
            layout_reg <= layout_fmt;
        end
    end

    assign command.valid            = valid_reg;
    assign command.cmd_kind         = kind_reg;
    assign command.cmd_number       = number_reg;
    assign command.node_ident       = node_reg;
    assign command.small_field      = small_reg;
    assign command.parent_or_length = plen_reg;
    assign command.pos_x            = layout_reg[63:48];
    assign command.pos_y            = layout_reg[47:32];
    assign command.size_w           = layout_reg[31:16];
    assign command.size_h           = layout_reg[15:0];

endmodule

// ===== rtl/core/binary_command_stream_parser.sv =====
// ----------------------------------------------------------------------------
// binary_command_stream_parser
// Parses command frames one word per cycle while the queue has room and emits
// one command word per completed command.
// ----------------------------------------------------------------------------
// Throughput: one frame word and one command word per cycle, while the queue
// has room and the output word is taken. A completed command is written into
// the queue, then into the output register once that is empty or being taken.
// Input ready drops only while the command queue holds QUEUE_DEPTH entries.
// Reset: rst_n clears the parse phase and counters, the queue pointers and the
// output valid at once; there is no clearing pass.
module binary_command_stream_parser
    import bcsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2   // at least 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    bcsp_byte_if.sink  frame,
    bcsp_cmd_if.source command
);

    cmd_slot_t push_slot;
    cmd_slot_t head_slot;
    logic      queue_full;
    logic      queue_pop;

    bcsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame      (frame),
        .queue_full (queue_full),
        .push       (push_slot)
    );

    bcsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push_slot),
        .pop   (queue_pop),
        .head  (head_slot),
        .full  (queue_full)
    );

    bcsp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head_slot),
        .pop     (queue_pop),
        .command (command)
    );

    // A command pushed into an empty pipeline reaches the output through the queue and the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_slot.valid && !head_slot.valid && !command.valid) |=> ##1 command.valid)
        else $error("pushed command did not reach the output");

    // Taking a command word with nothing pushed frees room for the next input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (command.valid && command.ready && !push_slot.valid) |=> frame.ready)
        else $error("input stalled after the output drained");

    // Layout fields are zero on every other kind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (command.valid && command.cmd_kind != KIND_LAYOUT) |->
        (command.pos_x == 16'sd0 && command.pos_y == 16'sd0 &&
         command.size_w == 16'd0 && command.size_h == 16'd0))
        else $error("layout fields set on a non-layout command");

endmodule
